@@ rtl/upd_pkg.sv @@
// Package for the URL path percent decoder: item and status types, character
// codes shared by both parts, and the hex digit decode of the front part.
// No dependencies.
package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_ESCAPE   = 3'd1,
    ST_EMPTY        = 3'd2,
    ST_NOT_ABSOLUTE = 3'd3,
    ST_DOT_DOT      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  // One classified input beat as it travels from the front to the back part.
  typedef struct packed {
    logic [7:0] raw;
    logic       no_byte;
    logic       last;
    logic       is_percent;
    logic       is_plus;
    logic       hex_ok;
    logic [3:0] hex_val;
  } item_t;

  // Bit 4 set means the byte is a hex digit; bits 3:0 hold its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

@@ rtl/upd_front.sv @@
// Front part of the URL path percent decoder: takes input beats, classifies
// each byte (percent, plus, hex digit) and holds it until the queue takes it.
// Depends on upd_pkg.
module upd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_no_byte,
  input  logic          in_last,
  output logic          push,
  input  logic          q_ready,
  output upd_pkg::item_t push_item
);

  upd_pkg::item_t item_r;
  upd_pkg::item_t item_nxt;
  logic           valid_r;
  logic           valid_nxt;
  logic [4:0]     hex;

  assign hex      = upd_pkg::hex_decode(in_byte);
  assign push     = valid_r && q_ready;
  assign in_ready = !valid_r || q_ready;
  assign push_item = item_r;

  always_comb begin
    item_nxt            = item_r;
    valid_nxt           = valid_r;
    if (push) begin
      valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      item_nxt.raw        = in_byte;
      item_nxt.no_byte    = in_no_byte;
      item_nxt.last       = in_last;
      item_nxt.is_percent = (in_byte == upd_pkg::CH_PERCENT);
      item_nxt.is_plus    = (in_byte == upd_pkg::CH_PLUS);
      item_nxt.hex_ok     = hex[4];
      item_nxt.hex_val    = hex[3:0];
      valid_nxt           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

@@ rtl/upd_queue.sv @@
// Short queue of classified items between the front and back parts.
// Depends on upd_pkg.
module upd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           push_ready,
  input  upd_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop,
  output upd_pkg::item_t pop_item
);

  upd_pkg::item_t                  slots_r [upd_pkg::QUEUE_DEPTH];
  logic [upd_pkg::QUEUE_AW-1:0]    wr_ptr_r;
  logic [upd_pkg::QUEUE_AW-1:0]    wr_ptr_nxt;
  logic [upd_pkg::QUEUE_AW-1:0]    rd_ptr_r;
  logic [upd_pkg::QUEUE_AW-1:0]    rd_ptr_nxt;
  logic [upd_pkg::QUEUE_AW:0]      count_r;
  logic [upd_pkg::QUEUE_AW:0]      count_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (count_r != (upd_pkg::QUEUE_AW+1)'(upd_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slots_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/upd_back.sv @@
// Back part of the URL path percent decoder: escape state machine, path
// checks, status on the closing beat and the output register.
// Depends on upd_pkg.
module upd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           pop,
  input  upd_pkg::item_t item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_byte_valid,
  output logic           out_done,
  output logic [2:0]     out_status
);

  upd_pkg::phase_t  phase_r, phase_nxt;
  logic [3:0]       high_r, high_nxt;
  logic             err_r, err_nxt;
  logic             any_r, any_nxt;
  logic             fns_r, fns_nxt;
  logic             pdot_r, pdot_nxt;
  logic             dd_r, dd_nxt;

  logic             res_v_r, res_v_nxt;
  logic [7:0]       res_byte_r, res_byte_nxt;
  logic             res_bv_r, res_bv_nxt;
  logic             res_done_r, res_done_nxt;
  upd_pkg::status_t res_st_r, res_st_nxt;

  logic             take;
  logic             bval;
  logic [7:0]       ob;
  logic             err_end;

  assign take = q_valid && (!res_v_r || out_ready);
  assign pop  = take;

  always_comb begin
    phase_nxt    = phase_r;
    high_nxt     = high_r;
    err_nxt      = err_r;
    any_nxt      = any_r;
    fns_nxt      = fns_r;
    pdot_nxt     = pdot_r;
    dd_nxt       = dd_r;
    res_v_nxt    = res_v_r && !out_ready;
    res_byte_nxt = res_byte_r;
    res_bv_nxt   = res_bv_r;
    res_done_nxt = res_done_r;
    res_st_nxt   = res_st_r;
    bval         = 1'b0;
    ob           = 8'd0;
    err_end      = 1'b0;

    if (take) begin
      if (!item.no_byte && !err_r) begin
        unique case (phase_r)
          upd_pkg::PH_IDLE: begin
            if (item.is_percent) begin
              phase_nxt = upd_pkg::PH_HIGH;
            end else begin
              ob   = item.is_plus ? upd_pkg::CH_SPACE : item.raw;
              bval = 1'b1;
            end
          end
          upd_pkg::PH_HIGH: begin
            if (!item.hex_ok) begin
              err_nxt   = 1'b1;
              phase_nxt = upd_pkg::PH_IDLE;
            end else begin
              high_nxt  = item.hex_val;
              phase_nxt = upd_pkg::PH_LOW;
            end
          end
          upd_pkg::PH_LOW: begin
            phase_nxt = upd_pkg::PH_IDLE;
            if (!item.hex_ok) begin
              err_nxt = 1'b1;
            end else begin
              ob   = {high_r, item.hex_val};
              bval = 1'b1;
            end
          end
          default: begin
            phase_nxt = upd_pkg::PH_IDLE;
          end
        endcase
        if (bval) begin
          if (!any_r && ob != upd_pkg::CH_SLASH) begin
            fns_nxt = 1'b1;
          end
          any_nxt  = 1'b1;
          pdot_nxt = (ob == upd_pkg::CH_DOT);
          if (ob == upd_pkg::CH_DOT && pdot_r) begin
            dd_nxt = 1'b1;
          end
        end
      end

      if (bval || item.last) begin
        res_v_nxt    = 1'b1;
        res_byte_nxt = ob;
        res_bv_nxt   = bval;
        res_done_nxt = item.last;
        res_st_nxt   = upd_pkg::ST_OK;
        if (item.last) begin
          err_end = err_nxt || (phase_nxt != upd_pkg::PH_IDLE);
          priority if (err_end) begin
            res_st_nxt = upd_pkg::ST_BAD_ESCAPE;
          end else if (!any_nxt) begin
            res_st_nxt = upd_pkg::ST_EMPTY;
          end else if (fns_nxt) begin
            res_st_nxt = upd_pkg::ST_NOT_ABSOLUTE;
          end else if (dd_nxt) begin
            res_st_nxt = upd_pkg::ST_DOT_DOT;
          end else begin
            res_st_nxt = upd_pkg::ST_OK;
          end
        end
      end

      // The closing beat returns the path state to its reset values.
      if (item.last) begin
        phase_nxt = upd_pkg::PH_IDLE;
        high_nxt  = 4'd0;
        err_nxt   = 1'b0;
        any_nxt   = 1'b0;
        fns_nxt   = 1'b0;
        pdot_nxt  = 1'b0;
        dd_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_byte_r <= res_byte_nxt;
    res_bv_r   <= res_bv_nxt;
    res_done_r <= res_done_nxt;
    res_st_r   <= res_st_nxt;
    if (!rst_n) begin
      phase_r <= upd_pkg::PH_IDLE;
      high_r  <= 4'd0;
      err_r   <= 1'b0;
      any_r   <= 1'b0;
      fns_r   <= 1'b0;
      pdot_r  <= 1'b0;
      dd_r    <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      high_r  <= high_nxt;
      err_r   <= err_nxt;
      any_r   <= any_nxt;
      fns_r   <= fns_nxt;
      pdot_r  <= pdot_nxt;
      dd_r    <= dd_nxt;
      res_v_r <= res_v_nxt;
    end
  end

  assign out_valid      = res_v_r;
  assign out_byte       = res_byte_r;
  assign out_byte_valid = res_bv_r;
  assign out_done       = res_done_r;
  assign out_status     = res_st_r;

endmodule

@@ rtl/url_path_percent_decoder.sv @@
// Top level of the URL path percent decoder.
// Depends on upd_pkg, upd_front, upd_queue and upd_back.
//
// Usage: the request URI arrives on the in_ stream, one byte per beat, with
// in_tlast on the final beat. in_tuser[0] set means the beat carries no byte
// (used to close an empty URI). Decoded bytes leave on the out_ stream; the
// beat that closes a URI has out_tlast set and carries the path status:
// 0 ok, 1 bad escape, 2 empty, 3 not absolute, 4 contains "..". A beat with
// out_tlast may also carry a decoded byte, flagged by out_tuser[0].
// An input beat that decodes to nothing and is not last gives no output beat.
// Timing: one input beat per cycle is sustained while out_tready is high.
// A beat passes the registered classification stage, a queue slot and the
// output register on its way to the output.
// Stalls: when out_tready is low the output register holds its beat, the
// four-entry queue fills and in_tready drops once the queue and the front
// register are full; nothing is lost. After a bad escape, the rest of the URI
// is consumed without output and closed with the bad escape status.
// Reset: rst_n low at a rising edge empties the queue and output register
// and returns the escape state and path checks to idle.
module url_path_percent_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic [0:0]  in_tuser,   // [0] no_byte
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [10:8] status, rest zero
  output logic [0:0]  out_tuser,  // [0] out_byte_valid
  output logic        out_tlast   // out_done
);

  logic           push;
  logic           q_ready;
  upd_pkg::item_t push_item;
  logic           q_valid;
  logic           pop;
  upd_pkg::item_t pop_item;
  logic [7:0]     res_byte;
  logic           res_bv;
  logic [2:0]     res_status;

  upd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_no_byte (in_tuser[0]),
    .in_last    (in_tlast),
    .push       (push),
    .q_ready    (q_ready),
    .push_item  (push_item)
  );

  upd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (q_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  upd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .pop            (pop),
    .item           (pop_item),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_byte       (res_byte),
    .out_byte_valid (res_bv),
    .out_done       (out_tlast),
    .out_status     (res_status)
  );

  assign out_tdata = {5'd0, res_status, res_byte};
  assign out_tuser = res_bv;

endmodule
